// ----- design/brf_pkg.sv -----
// Shared types and constants of the byte ring FIFO.
// Used by the bank RAM, the lane mapper and the top level; no dependencies.
`default_nettype none

package brf_pkg;

  localparam int RING_DEPTH   = 1024;
  localparam int MAX_TRANSFER = 8;
  localparam int NUM_BANKS    = MAX_TRANSFER;
  localparam int ADDR_W       = $clog2(RING_DEPTH);
  localparam int BANK_W       = $clog2(NUM_BANKS);
  localparam int ROW_W        = ADDR_W - BANK_W;
  localparam int BANK_ROWS    = RING_DEPTH / NUM_BANKS;
  localparam int SIZE_W       = 11;
  localparam int LEN_W        = 11;
  localparam int CNT_W        = $clog2(MAX_TRANSFER + 1);
  localparam int DATA_W       = 8 * MAX_TRANSFER;
  localparam int COUNT_W      = 10;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(RING_DEPTH);

  typedef enum logic [1:0] {
    ACT_PUT  = 2'd0,
    ACT_GET  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_SKIP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_ZERO_LEN = 2'd1,
    STAT_NO_ROOM  = 2'd2,
    STAT_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WRAP,
    S_FIN
  } state_e;

  // One bank's share of a transfer segment
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    logic [BANK_W-1:0] idx;
  } lane_t;

endpackage

`default_nettype wire

// ----- design/brf_bank.sv -----
// One byte-wide bank of the ring memory, one row per cycle, registered read.
// Depends on brf_pkg for the row count and address width.
`default_nettype none

module brf_bank (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic                      re_i,
  input  logic [brf_pkg::ROW_W-1:0] addr_i,
  input  logic [7:0]                wdata_i,
  output logic [7:0]                rdata_o
);
  import brf_pkg::*;

  logic [7:0] mem [BANK_ROWS];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/brf_lane_map.sv -----
// Maps one contiguous address segment of a transfer onto the byte banks.
// Depends on brf_pkg for lane_t and the bank geometry.
`default_nettype none

module brf_lane_map (
  input  logic [brf_pkg::ADDR_W-1:0]                   start_i,
  input  logic [brf_pkg::BANK_W-1:0]                   off_i,
  input  logic [brf_pkg::CNT_W-1:0]                    cnt_i,
  output brf_pkg::lane_t [brf_pkg::NUM_BANKS-1:0]      lanes_o
);
  import brf_pkg::*;

  logic [BANK_W-1:0] jrel;
  logic [ADDR_W-1:0] addr;

  // Bank b holds segment byte (b - start) mod banks; consecutive addresses
  // never share a bank inside one segment.
  always_comb begin
    jrel = '0;
    addr = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      jrel = BANK_W'(b) - start_i[BANK_W-1:0];
      addr = start_i + ADDR_W'(jrel);
      lanes_o[b].en  = CNT_W'(jrel) < cnt_i;
      lanes_o[b].row = addr[ADDR_W-1:BANK_W];
      lanes_o[b].idx = off_i + jrel;
    end
  end

endmodule

`default_nettype wire

// ----- design/byte_ring_fifo.sv -----
// Byte ring FIFO: put, get, peek and skip on a ring of ring_size bytes held
// in eight byte banks. The accept cycle checks room and issues the bank access;
// in S_FIN the registered bank data is merged into the result, which is
// loaded into the output register once it is free. A put, get or peek that
// runs across the end of the ring needs a second bank access in S_WRAP first.
// The next operation is taken once the result sits in the output register.
// Writing ring_size empties the ring; there is no clearing pass after reset.
// Depends on brf_pkg, brf_bank and brf_lane_map.
`default_nettype none

module byte_ring_fifo (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: ring_size
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i,
  // operations in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // transfer_length[10:0], put_bytes[74:11], zero
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  // results out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // read_bytes[63:0], bytes_used[73:64],
                                      // bytes_free[83:74], zero
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import brf_pkg::*;

  state_e               state_q, state_d;
  logic [SIZE_W-1:0]    ring_size_q;
  logic [ADDR_W-1:0]    wp_q, wp_d, rp_q, rp_d;
  action_e              op_q;
  logic [DATA_W-1:0]    put_q;
  logic [CNT_W-1:0]     n1_q, n2_q;
  status_e              status_q;
  logic [COUNT_W-1:0]   used_q, free_q;
  logic [DATA_W-1:0]    rd_acc_q;
  logic [NUM_BANKS-1:0] lane_rd_q;
  logic [BANK_W-1:0]    lane_idx_q [NUM_BANKS];
  logic                 m_valid_q, m_valid_d;
  logic [87:0]          m_data_q;
  status_e              m_status_q;

  // input fields
  action_e              act;
  logic [LEN_W-1:0]     len;
  logic [DATA_W-1:0]    put_bytes;

  logic                 acc, cfg_acc, out_free, load_out;
  logic [SIZE_W-1:0]    used, room_end, used_after, free_after, cfg_size;
  logic [ADDR_W-1:0]    ptr;
  logic [SIZE_W:0]      ptr_sum;
  logic [ADDR_W-1:0]    ptr_next;
  status_e              status;
  logic                 ok, xfer, wrap;
  logic [CNT_W-1:0]     n1, n2;

  logic                 issue_wr, issue_rd, issue;
  logic [ADDR_W-1:0]    seg_start;
  logic [BANK_W-1:0]    seg_off;
  logic [CNT_W-1:0]     seg_cnt;
  logic [DATA_W-1:0]    src_data;
  lane_t [NUM_BANKS-1:0] lanes;
  logic [7:0]           bank_rdata [NUM_BANKS];
  logic [DATA_W-1:0]    placed;

  assign act       = action_e'(s_axis_tuser[1:0]);
  assign len       = s_axis_tdata[LEN_W-1:0];
  assign put_bytes = s_axis_tdata[LEN_W +: DATA_W];

  assign acc     = s_axis_tvalid && s_axis_tready;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign out_free = !m_valid_q || m_axis_tready;
  assign load_out = (state_q == S_FIN) && out_free;

  // ---------------- operation check and pointer update ----------------
  always_comb begin
    if (wp_q >= rp_q) begin
      used = SIZE_W'(wp_q) - SIZE_W'(rp_q);
    end else begin
      used = ring_size_q - SIZE_W'(rp_q) + SIZE_W'(wp_q);
    end

    if (len == '0) begin
      status = STAT_ZERO_LEN;
    end else if (act != ACT_SKIP && len > LEN_W'(MAX_TRANSFER)) begin
      status = STAT_TOO_LONG;
    end else if (act == ACT_PUT) begin
      status = (ring_size_q - used <= len) ? STAT_NO_ROOM : STAT_DONE;
    end else begin
      status = (used < len) ? STAT_NO_ROOM : STAT_DONE;
    end
    ok   = (status == STAT_DONE);
    xfer = ok && (act != ACT_SKIP);

    ptr      = (act == ACT_PUT) ? wp_q : rp_q;
    room_end = ring_size_q - SIZE_W'(ptr);
    wrap     = len > room_end;
    n1       = wrap ? room_end[CNT_W-1:0] : len[CNT_W-1:0];
    n2       = len[CNT_W-1:0] - n1;

    ptr_sum = (SIZE_W+1)'(ptr) + (SIZE_W+1)'(len);
    if (ptr_sum >= (SIZE_W+1)'(ring_size_q)) begin
      ptr_sum = ptr_sum - (SIZE_W+1)'(ring_size_q);
    end
    ptr_next = ptr_sum[ADDR_W-1:0];

    wp_d = wp_q;
    rp_d = rp_q;
    used_after = used;
    if (acc && ok) begin
      case (act)
        ACT_PUT: begin
          wp_d = ptr_next;
          used_after = used + len;
        end
        ACT_GET, ACT_SKIP: begin
          rp_d = ptr_next;
          used_after = used - len;
        end
        default: begin
          used_after = used;
        end
      endcase
    end
    free_after = ring_size_q - used_after - SIZE_W'(1);

    cfg_size = cfg_data_i;
    if (cfg_data_i < SIZE_MIN) begin
      cfg_size = SIZE_MIN;
    end else if (cfg_data_i > SIZE_MAX) begin
      cfg_size = SIZE_MAX;
    end
  end

  // ---------------- bank access ----------------
  always_comb begin
    issue_wr = 1'b0;
    issue_rd = 1'b0;
    if (state_q == S_IDLE) begin
      issue_wr = acc && xfer && (act == ACT_PUT);
      issue_rd = acc && xfer && (act != ACT_PUT);
      seg_start = ptr;
      seg_off   = '0;
      seg_cnt   = n1;
      src_data  = put_bytes;
    end else begin
      issue_wr = (state_q == S_WRAP) && (op_q == ACT_PUT);
      issue_rd = (state_q == S_WRAP) && (op_q != ACT_PUT);
      seg_start = '0;
      seg_off   = n1_q[BANK_W-1:0];
      seg_cnt   = n2_q;
      src_data  = put_q;
    end
    issue = acc || (state_q == S_WRAP);
  end

  brf_lane_map u_lane_map (
    .start_i (seg_start),
    .off_i   (seg_off),
    .cnt_i   (seg_cnt),
    .lanes_o (lanes)
  );

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    brf_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (issue_wr && lanes[b].en),
      .re_i    (issue_rd && lanes[b].en),
      .addr_i  (lanes[b].row),
      .wdata_i (src_data[{lanes[b].idx, 3'b000} +: 8]),
      .rdata_o (bank_rdata[b])
    );
  end

  // Place the bank data of the last read pass at its byte positions
  always_comb begin
    placed = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if (lane_rd_q[b]) begin
        placed[{lane_idx_q[b], 3'b000} +: 8] = bank_rdata[b];
      end
    end
  end

  // ---------------- control ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          state_d = (xfer && wrap) ? S_WRAP : S_FIN;
        end
      end
      S_WRAP: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    cfg_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = !cfg_valid_i;
        cfg_ready_o   = 1'b1;
      end
      default: begin
        s_axis_tready = 1'b0;
        cfg_ready_o   = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ring_size_q <= SIZE_MAX;
      wp_q        <= '0;
      rp_q        <= '0;
      m_valid_q   <= 1'b0;
      lane_rd_q   <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_acc) begin
        ring_size_q <= cfg_size;
        wp_q        <= '0;
        rp_q        <= '0;
      end else begin
        wp_q <= wp_d;
        rp_q <= rp_d;
      end
      if (issue) begin
        for (int b = 0; b < NUM_BANKS; b++) begin
          lane_rd_q[b] <= issue_rd && lanes[b].en;
        end
      end
    end
  end

  // ---------------- payload ----------------
  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        lane_idx_q[b] <= lanes[b].idx;
      end
    end
    if (acc) begin
      op_q     <= act;
      put_q    <= put_bytes;
      n1_q     <= n1;
      n2_q     <= n2;
      status_q <= status;
      used_q   <= used_after[COUNT_W-1:0];
      free_q   <= free_after[COUNT_W-1:0];
      rd_acc_q <= '0;
    end else if (state_q == S_WRAP) begin
      // hold the first pass before the second one overwrites the bank data
      rd_acc_q <= rd_acc_q | placed;
    end
    if (load_out) begin
      m_data_q   <= {4'b0000, free_q, used_q, rd_acc_q | placed};
      m_status_q <= status_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

endmodule

`default_nettype wire
